// File: rtl/dpq_pkg.sv
// ----------------------------------------------------------------------------
// Door position qualifier package
// Shared types, state codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dpq_pkg;

    localparam int LOG_DEPTH_DEF = 32;

    localparam logic [1:0] DOOR_INBETWEEN = 2'd0;
    localparam logic [1:0] DOOR_OPENED    = 2'd1;
    localparam logic [1:0] DOOR_CLOSED    = 2'd2;

    localparam logic [1:0] CFG_STABLE_TIME  = 2'd0;
    localparam logic [1:0] CFG_INB_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_TICKS_PER_S  = 2'd2;

    localparam logic [15:0] STABLE_TIME_RST = 16'd2000;
    localparam logic [15:0] INB_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] TICKS_PER_S_RST = 16'd1000;
    localparam logic [15:0] QUIET_RST       = 16'd3000;

    typedef struct packed {
        logic [1:0]  door;
        logic [31:0] seconds;
        logic        by_app;
        logic [15:0] latency;
    } t_entry;

    typedef struct packed {
        logic        push;
        logic        sec_wr;
        logic [31:0] elapsed;
    } t_log_ctl;

endpackage

// File: rtl/dpq_cell.sv
// ----------------------------------------------------------------------------
// Door event log cell
// One log entry; loads from its upstream neighbor on a push, and the head
// cell also takes a seconds refresh.
// ----------------------------------------------------------------------------
module dpq_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_sec_wr,
    input  logic [31:0]     i_seconds,
    input  dpq_pkg::t_entry i_entry,
    output dpq_pkg::t_entry o_entry
);

    dpq_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end else if (i_sec_wr) begin
            r_entry.seconds <= i_seconds;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/dpq_qual.sv
// ----------------------------------------------------------------------------
// Door state qualifier
// Config registers, edge/timeout door state, stability hold, seconds
// counter and log push control.
// ----------------------------------------------------------------------------
module dpq_qual #(
    parameter int LOG_DEPTH = dpq_pkg::LOG_DEPTH_DEF,
    parameter int CNT_W     = $clog2(LOG_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_step,
    input  logic              i_opened_edge,
    input  logic              i_closed_edge,
    input  logic              i_opened_level,
    input  logic              i_closed_level,
    input  logic              i_app_cause_set,
    input  logic [15:0]       i_app_latency,
    output dpq_pkg::t_log_ctl o_ctl,
    output dpq_pkg::t_entry   o_new_entry,
    output logic [1:0]        o_door_state,
    output logic [1:0]        o_stable_state,
    output logic [CNT_W-1:0]  o_count
);

    logic [15:0]      r_stable_time, r_inb_timeout, r_ticks_per_s;
    logic [1:0]       r_door, r_door_before, r_stable;
    logic [15:0]      r_hold, r_quiet, r_ms;
    logic [31:0]      r_seconds, r_last_event;
    logic             r_pend_app;
    logic [15:0]      r_pend_lat;
    logic [CNT_W-1:0] r_count;

    logic [1:0]       n_door;
    logic [15:0]      n_hold, n_quiet, n_ms;
    logic [31:0]      n_seconds;
    logic             n_pend_app;
    logic [15:0]      n_pend_lat;
    logic [CNT_W-1:0] n_count;
    logic [16:0]      ms_inc;
    logic             sec_tick, expired, edge_seen, push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_time <= dpq_pkg::STABLE_TIME_RST;
            r_inb_timeout <= dpq_pkg::INB_TIMEOUT_RST;
            r_ticks_per_s <= dpq_pkg::TICKS_PER_S_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dpq_pkg::CFG_STABLE_TIME: r_stable_time <= i_cfg_data;
                dpq_pkg::CFG_INB_TIMEOUT: r_inb_timeout <= i_cfg_data;
                dpq_pkg::CFG_TICKS_PER_S: r_ticks_per_s <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ms_inc    = {1'b0, r_ms} + 17'd1;
        sec_tick  = ms_inc >= {1'b0, r_ticks_per_s};
        n_ms      = sec_tick ? 16'd0 : ms_inc[15:0];
        n_seconds = (sec_tick && (r_seconds != '1)) ? r_seconds + 32'd1 : r_seconds;

        expired   = r_quiet <= 16'd1;
        edge_seen = i_opened_edge || i_closed_edge;
        n_door    = r_door;
        if (i_opened_edge) begin
            n_door = dpq_pkg::DOOR_OPENED;
        end
        if (i_closed_edge) begin
            n_door = dpq_pkg::DOOR_CLOSED;
        end
        if (expired && i_opened_level && i_closed_level) begin
            n_door = dpq_pkg::DOOR_INBETWEEN;
        end
        if (edge_seen || expired) begin
            n_quiet = r_inb_timeout;
        end else if (r_quiet != 16'd0) begin
            n_quiet = r_quiet - 16'd1;
        end else begin
            n_quiet = r_quiet;
        end

        if (r_door_before != n_door) begin
            n_hold = 16'd0;
        end else if (r_hold != '1) begin
            n_hold = r_hold + 16'd1;
        end else begin
            n_hold = r_hold;
        end

        push = (r_stable != n_door) && (n_hold > r_stable_time) &&
               (n_door != dpq_pkg::DOOR_INBETWEEN);

        n_pend_app = i_app_cause_set || r_pend_app;
        n_pend_lat = i_app_cause_set ? i_app_latency : r_pend_lat;

        n_count = (push && (r_count < CNT_W'(LOG_DEPTH))) ? r_count + 1'b1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door        <= dpq_pkg::DOOR_INBETWEEN;
            r_door_before <= dpq_pkg::DOOR_INBETWEEN;
            r_stable      <= dpq_pkg::DOOR_INBETWEEN;
            r_hold        <= '0;
            r_quiet       <= dpq_pkg::QUIET_RST;
            r_ms          <= '0;
            r_seconds     <= '0;
            r_last_event  <= '0;
            r_pend_app    <= 1'b0;
            r_pend_lat    <= '0;
            r_count       <= '0;
        end else if (i_step) begin
            r_door        <= n_door;
            r_door_before <= n_door;
            r_hold        <= n_hold;
            r_quiet       <= n_quiet;
            r_ms          <= n_ms;
            r_seconds     <= n_seconds;
            r_pend_lat    <= n_pend_lat;
            r_count       <= n_count;
            r_pend_app    <= push ? 1'b0 : n_pend_app;
            if (push) begin
                r_stable     <= n_door;
                r_last_event <= n_seconds;
            end
        end
    end

    assign o_ctl.push    = i_step && push;
    assign o_ctl.sec_wr  = i_step && sec_tick && (r_count != '0);
    assign o_ctl.elapsed = n_seconds - r_last_event;

    assign o_new_entry.door    = n_door;
    assign o_new_entry.seconds = 32'd0;
    assign o_new_entry.by_app  = n_pend_app;
    assign o_new_entry.latency = n_pend_lat;

    assign o_door_state   = r_door;
    assign o_stable_state = r_stable;
    assign o_count        = r_count;

endmodule

// File: rtl/door_position_qualifier_with_event_log.sv
// ----------------------------------------------------------------------------
// Door position qualifier with event log
// Qualifies door sensor ticks and keeps a shift log of stable door changes.
// ----------------------------------------------------------------------------
// Path: an input transaction updates the state, then the log is read into the
//   output register.
// Throughput: one transaction per cycle unless the output stalls; the log chain shifts all cells at once.
// Reset: synchronous, active low; clears counters, state and entry count.
//   Log cells are not cleared; the entry count masks stale contents.
// ----------------------------------------------------------------------------
module door_position_qualifier_with_event_log #(
    parameter int LOG_DEPTH = dpq_pkg::LOG_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opened_edge,
    input  logic        i_closed_edge,
    input  logic        i_opened_level,
    input  logic        i_closed_level,
    input  logic        i_app_cause_set,
    input  logic [15:0] i_app_latency,
    input  logic [4:0]  i_read_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_door_state,
    output logic [1:0]  o_stable_state,
    output logic        o_event_logged,
    output logic [5:0]  o_entry_count,
    output logic [1:0]  o_entry_door,
    output logic [31:0] o_entry_seconds,
    output logic        o_entry_by_app,
    output logic [15:0] o_entry_latency
);

    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int IDX_W = $clog2(LOG_DEPTH);

    dpq_pkg::t_log_ctl  log_ctl;
    dpq_pkg::t_entry    new_entry;
    dpq_pkg::t_entry    cell_q  [LOG_DEPTH];
    dpq_pkg::t_entry    cell_d  [LOG_DEPTH];
    dpq_pkg::t_entry    rd_entry;
    logic [1:0]         door_state, stable_state;
    logic [CNT_W-1:0]   count;
    logic [CNT_W+5:0]   count_ext;
    logic [IDX_W+4:0]   ridx_ext;
    logic               rd_hit;

    logic               in_acc, load_out;
    logic               r_a_valid, r_a_logged;
    logic [4:0]         r_a_ridx;
    logic               r_o_valid;

    assign in_acc   = i_valid && o_ready;
    assign load_out = r_a_valid && (!r_o_valid || i_ready);
    assign o_ready  = !r_a_valid || !r_o_valid || i_ready;

    dpq_qual #(
        .LOG_DEPTH (LOG_DEPTH),
        .CNT_W     (CNT_W)
    ) u_qual (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_step          (in_acc),
        .i_opened_edge   (i_opened_edge),
        .i_closed_edge   (i_closed_edge),
        .i_opened_level  (i_opened_level),
        .i_closed_level  (i_closed_level),
        .i_app_cause_set (i_app_cause_set),
        .i_app_latency   (i_app_latency),
        .o_ctl           (log_ctl),
        .o_new_entry     (new_entry),
        .o_door_state    (door_state),
        .o_stable_state  (stable_state),
        .o_count         (count)
    );

    for (genvar g = 0; g < LOG_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_d[g] = new_entry;
        end else if (g == 1) begin : g_second
            // head entry leaves with its final duration
            assign cell_d[g] = '{door:    cell_q[0].door,
                                 seconds: log_ctl.elapsed,
                                 by_app:  cell_q[0].by_app,
                                 latency: cell_q[0].latency};
        end else begin : g_rest
            assign cell_d[g] = cell_q[g-1];
        end

        dpq_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (log_ctl.push),
            .i_sec_wr  ((g == 0) ? log_ctl.sec_wr : 1'b0),
            .i_seconds (log_ctl.elapsed),
            .i_entry   (cell_d[g]),
            .o_entry   (cell_q[g])
        );
    end

    always_comb begin
        count_ext = {6'd0, count};
        ridx_ext  = {{IDX_W{1'b0}}, r_a_ridx};
        rd_hit    = {{(CNT_W+1){1'b0}}, r_a_ridx} < count_ext;
        rd_entry  = cell_q[ridx_ext[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (load_out) begin
                r_a_valid <= 1'b0;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_logged <= log_ctl.push;
            r_a_ridx   <= i_read_index;
        end
        if (load_out) begin
            o_door_state    <= door_state;
            o_stable_state  <= stable_state;
            o_event_logged  <= r_a_logged;
            o_entry_count   <= count_ext[5:0];
            o_entry_door    <= rd_hit ? rd_entry.door    : dpq_pkg::DOOR_INBETWEEN;
            o_entry_seconds <= rd_hit ? rd_entry.seconds : 32'd0;
            o_entry_by_app  <= rd_hit ? rd_entry.by_app  : 1'b0;
            o_entry_latency <= rd_hit ? rd_entry.latency : 16'd0;
        end
    end

    assign o_valid = r_o_valid;

endmodule

// File: rtl/dpq_chk.sv
// ----------------------------------------------------------------------------
// Door position qualifier checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dpq_chk #(
    parameter int LOG_DEPTH = dpq_pkg::LOG_DEPTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_door_state,
    input logic [1:0]  o_stable_state,
    input logic        o_event_logged,
    input logic [5:0]  o_entry_count,
    input logic [1:0]  o_entry_door,
    input logic [31:0] o_entry_seconds,
    input logic        o_entry_by_app,
    input logic [15:0] o_entry_latency
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_entry_seconds))
        else $error("result dropped or changed while stalled");

    a_logged_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_logged |->
            o_stable_state == o_door_state &&
            o_door_state != dpq_pkg::DOOR_INBETWEEN)
        else $error("logged transaction with inconsistent state");

    a_logged_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_logged |-> (LOG_DEPTH == 64) || (o_entry_count != 6'd0))
        else $error("logged transaction with empty log");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, o_entry_count} <= 7'(LOG_DEPTH))
        else $error("entry count beyond log depth");

    a_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_door == dpq_pkg::DOOR_INBETWEEN |->
            o_entry_seconds == 32'd0 && !o_entry_by_app && o_entry_latency == 16'd0)
        else $error("missing entry shows nonzero fields");

endmodule

bind door_position_qualifier_with_event_log dpq_chk #(.LOG_DEPTH(LOG_DEPTH)) u_dpq_chk (.*);

// File: tb/sv/door_event_checker.sv
// ----------------------------------------------------------------------------
// Door qualifier result checker
// Watches both transaction channels and the register port, predicts the
// result of every accepted sensor tick and compares each returned result
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module door_event_checker #(
    parameter int LOG_DEPTH = dpq_pkg::LOG_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_opened_edge,
    input  logic        i_closed_edge,
    input  logic        i_opened_level,
    input  logic        i_closed_level,
    input  logic        i_app_cause_set,
    input  logic [15:0] i_app_latency,
    input  logic [4:0]  i_read_index,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_door_state,
    input  logic [1:0]  i_stable_state,
    input  logic        i_event_logged,
    input  logic [5:0]  i_entry_count,
    input  logic [1:0]  i_entry_door,
    input  logic [31:0] i_entry_seconds,
    input  logic        i_entry_by_app,
    input  logic [15:0] i_entry_latency,
    output int          o_fail_count,
    output int          o_open_count
);

    typedef struct packed {
        logic [1:0]      door_state;
        logic [1:0]      stable_state;
        logic            event_logged;
        logic [5:0]      entry_count;
        dpq_pkg::t_entry entry;
    } t_door_result;

    logic [15:0]     cfg_stable_time;
    logic [15:0]     cfg_inb_timeout;
    logic [15:0]     cfg_ticks_per_s;
    logic [1:0]      door_now;
    logic [1:0]      door_prev;
    logic [1:0]      door_stable;
    logic [15:0]     hold_ms;
    logic [15:0]     quiet_ms;
    logic [15:0]     ms_in_sec;
    logic [31:0]     sec_count;
    logic [31:0]     sec_at_event;
    logic            pend_app;
    logic [15:0]     pend_latency;
    dpq_pkg::t_entry door_log [LOG_DEPTH];
    int unsigned     entries;
    t_door_result    results_due [$];
    int              mismatches = 0;

    function automatic t_door_result advance_door_tick(
        input logic        oe,
        input logic        ce,
        input logic        ol,
        input logic        cl,
        input logic        app,
        input logic [15:0] lat,
        input logic [4:0]  ridx
    );
        t_door_result res;
        logic         expired;
        int           k;
        res = '0;
        if (app) begin
            pend_app     = 1'b1;
            pend_latency = lat;
        end

        ms_in_sec = ms_in_sec + 16'd1;
        if (ms_in_sec >= cfg_ticks_per_s) begin
            ms_in_sec = '0;
            if (sec_count != 32'hFFFF_FFFF) sec_count = sec_count + 32'd1;
            if (entries > 0) door_log[0].seconds = sec_count - sec_at_event;
        end

        // edges first, closed wins, then the in-between check
        expired = (quiet_ms <= 16'd1);
        if (quiet_ms != 16'd0) quiet_ms = quiet_ms - 16'd1;
        if (oe) door_now = dpq_pkg::DOOR_OPENED;
        if (ce) door_now = dpq_pkg::DOOR_CLOSED;
        if (expired && ol && cl) door_now = dpq_pkg::DOOR_INBETWEEN;
        if (oe || ce || expired) quiet_ms = cfg_inb_timeout;

        if (door_prev != door_now) hold_ms = '0;
        else if (hold_ms != 16'hFFFF) hold_ms = hold_ms + 16'd1;

        if (door_stable != door_now && hold_ms > cfg_stable_time &&
            door_now != dpq_pkg::DOOR_INBETWEEN) begin
            door_stable = door_now;
            door_log[0].seconds = sec_count - sec_at_event;
            for (k = LOG_DEPTH - 1; k > 0; k--) door_log[k] = door_log[k - 1];
            door_log[0].door    = door_now;
            door_log[0].seconds = '0;
            door_log[0].by_app  = pend_app;
            door_log[0].latency = pend_latency;
            if (entries < LOG_DEPTH) entries++;
            pend_app     = 1'b0;
            sec_at_event = sec_count;
            res.event_logged = 1'b1;
        end
        door_prev = door_now;

        res.door_state   = door_now;
        res.stable_state = door_stable;
        res.entry_count  = entries[5:0];
        if (ridx < entries && ridx < LOG_DEPTH) res.entry = door_log[ridx];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h actual %0h at %0t",
                         name, want, got, $time);
        end
    endtask

    always @(posedge i_clk) begin
        t_door_result want;
        int           k;
        if (!i_rst_n) begin
            cfg_stable_time = dpq_pkg::STABLE_TIME_RST;
            cfg_inb_timeout = dpq_pkg::INB_TIMEOUT_RST;
            cfg_ticks_per_s = dpq_pkg::TICKS_PER_S_RST;
            door_now        = dpq_pkg::DOOR_INBETWEEN;
            door_prev       = dpq_pkg::DOOR_INBETWEEN;
            door_stable     = dpq_pkg::DOOR_INBETWEEN;
            hold_ms         = '0;
            quiet_ms        = dpq_pkg::QUIET_RST;
            ms_in_sec       = '0;
            sec_count       = '0;
            sec_at_event    = '0;
            pend_app        = 1'b0;
            pend_latency    = '0;
            entries         = 0;
            for (k = 0; k < LOG_DEPTH; k++) door_log[k] = '0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dpq_pkg::CFG_STABLE_TIME: cfg_stable_time = i_cfg_data;
                    dpq_pkg::CFG_INB_TIMEOUT: cfg_inb_timeout = i_cfg_data;
                    dpq_pkg::CFG_TICKS_PER_S: cfg_ticks_per_s = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(advance_door_tick(i_opened_edge, i_closed_edge,
                    i_opened_level, i_closed_level, i_app_cause_set, i_app_latency,
                    i_read_index));
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction at %0t", $time);
                end else begin
                    want = results_due.pop_front();
                    check_field("door_state", want.door_state, i_door_state);
                    check_field("stable_state", want.stable_state, i_stable_state);
                    check_field("event_logged", want.event_logged, i_event_logged);
                    check_field("entry_count", want.entry_count, i_entry_count);
                    check_field("entry_door", want.entry.door, i_entry_door);
                    check_field("entry_seconds", want.entry.seconds, i_entry_seconds);
                    check_field("entry_by_app", want.entry.by_app, i_entry_by_app);
                    check_field("entry_latency", want.entry.latency, i_entry_latency);
                end
            end
        end
        o_fail_count = mismatches;
        o_open_count = results_due.size();
    end

endmodule

// File: tb/sv/tb_door_position_qualifier_with_event_log.sv
// ----------------------------------------------------------------------------
// Door position qualifier testbench
// Drives millisecond sensor ticks through the block: a directed run over the
// corner cases, then open/closed/in-between sequences with random content
// under several register settings and idle patterns, a long output hold-off
// and a run at maximum register values. Results are checked by the door
// event checker.
// ----------------------------------------------------------------------------
module tb_door_position_qualifier_with_event_log;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_opened_edge;
    logic        i_closed_edge;
    logic        i_opened_level;
    logic        i_closed_level;
    logic        i_app_cause_set;
    logic [15:0] i_app_latency;
    logic [4:0]  i_read_index;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_door_state;
    logic [1:0]  o_stable_state;
    logic        o_event_logged;
    logic [5:0]  o_entry_count;
    logic [1:0]  o_entry_door;
    logic [31:0] o_entry_seconds;
    logic        o_entry_by_app;
    logic [15:0] o_entry_latency;

    int fail_count;
    int open_count;
    int send_idle_pct;
    int stall_pct;
    int rx_hold_len;
    int cur_stable;
    int cur_timeout;

    door_position_qualifier_with_event_log u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opened_edge  (i_opened_edge),
        .i_closed_edge  (i_closed_edge),
        .i_opened_level (i_opened_level),
        .i_closed_level (i_closed_level),
        .i_app_cause_set(i_app_cause_set),
        .i_app_latency  (i_app_latency),
        .i_read_index   (i_read_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_door_state   (o_door_state),
        .o_stable_state (o_stable_state),
        .o_event_logged (o_event_logged),
        .o_entry_count  (o_entry_count),
        .o_entry_door   (o_entry_door),
        .o_entry_seconds(o_entry_seconds),
        .o_entry_by_app (o_entry_by_app),
        .o_entry_latency(o_entry_latency)
    );

    door_event_checker u_door_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_opened_edge  (i_opened_edge),
        .i_closed_edge  (i_closed_edge),
        .i_opened_level (i_opened_level),
        .i_closed_level (i_closed_level),
        .i_app_cause_set(i_app_cause_set),
        .i_app_latency  (i_app_latency),
        .i_read_index   (i_read_index),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_door_state   (o_door_state),
        .i_stable_state (o_stable_state),
        .i_event_logged (o_event_logged),
        .i_entry_count  (o_entry_count),
        .i_entry_door   (o_entry_door),
        .i_entry_seconds(o_entry_seconds),
        .i_entry_by_app (o_entry_by_app),
        .i_entry_latency(o_entry_latency),
        .o_fail_count   (fail_count),
        .o_open_count   (open_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls plus an occasional long hold-off
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                i_ready = 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
            end
            i_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // called and returns at a falling edge; valid stays high into the next tick
    task automatic send_tick(input logic oe, input logic ce, input logic ol,
                             input logic cl, input logic app, input logic [15:0] lat,
                             input logic [4:0] ridx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_opened_edge   = oe;
        i_closed_edge   = ce;
        i_opened_level  = ol;
        i_closed_level  = cl;
        i_app_cause_set = app;
        i_app_latency   = lat;
        i_read_index    = ridx;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid = 1'b0;
        while (open_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic apply_setting(input int stable_t, input int timeout_t, input int tps);
        write_reg(dpq_pkg::CFG_STABLE_TIME, 16'(stable_t));
        write_reg(dpq_pkg::CFG_INB_TIMEOUT, 16'(timeout_t));
        write_reg(dpq_pkg::CFG_TICKS_PER_S, 16'(tps));
        cur_stable  = stable_t;
        cur_timeout = timeout_t;
    endtask

    function automatic logic [4:0] pick_read_index();
        return ($urandom_range(9) < 7) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
    endfunction

    // mostly clean open/closed/in-between holds, some pure noise ticks
    task automatic run_door_traffic(input int n_items);
        int   sent;
        int   len;
        int   pick;
        int   t;
        logic oe;
        logic ce;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_tick(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom), 16'($urandom), 5'($urandom));
                sent++;
            end else begin
                pick = $urandom_range(2);
                oe   = (pick == 1);
                ce   = (pick == 2);
                if (pick == 0) len = cur_timeout + $urandom_range(1, 4);
                else if ($urandom_range(9) == 0) len = $urandom_range(1, cur_stable + 1);
                else len = cur_stable + $urandom_range(0, 4);
                for (t = 0; t < len; t++) begin
                    send_tick((t == 0 || $urandom_range(19) == 0) ? oe : 1'b0,
                              (t == 0 || $urandom_range(19) == 0) ? ce : 1'b0,
                              pick != 1, pick != 2, $urandom_range(9) == 0,
                              16'($urandom), pick_read_index());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int n;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = dpq_pkg::CFG_STABLE_TIME;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_opened_edge   = 1'b0;
        i_closed_edge   = 1'b0;
        i_opened_level  = 1'b0;
        i_closed_level  = 1'b0;
        i_app_cause_set = 1'b0;
        i_app_latency   = '0;
        i_read_index    = '0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        rx_hold_len     = 0;
        cur_stable      = dpq_pkg::STABLE_TIME_RST;
        cur_timeout     = dpq_pkg::INB_TIMEOUT_RST;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings, empty log
        send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd31);
        send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0);
        drain_results();

        apply_setting(2, 3, 2);
        send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0);  // closed wins
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 16'hFFFF, 5'd1);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd1);
        send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd31);
        send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'h1234, 5'd1);  // mark on log tick
        send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd1);
        send_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd2);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd1);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd2);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd0);
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd3);  // edge on expiry
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd1);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd2);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 5'd31);
        drain_results();

        apply_setting(1, 1, 1);
        run_door_traffic(250);
        drain_results();

        send_idle_pct = 69;
        apply_setting($urandom_range(2, 6), $urandom_range(2, 8), $urandom_range(2, 20));
        run_door_traffic(250);
        drain_results();

        send_idle_pct = 0;
        stall_pct     = 69;
        apply_setting($urandom_range(2, 6), $urandom_range(1, 8), $urandom_range(1, 20));
        run_door_traffic(250);
        drain_results();

        // zero timeout and zero second length behave as one-tick periods
        send_idle_pct = 25;
        stall_pct     = 25;
        apply_setting(2, 0, 0);
        run_door_traffic(250);
        drain_results();

        // long output hold-off while ticks keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        apply_setting(3, 4, 5);
        rx_hold_len = 80;
        run_door_traffic(40);
        drain_results();

        // maximum register values: nothing may qualify
        apply_setting(65535, 65535, 65535);
        send_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0);
        for (n = 0; n < 100; n++)
            send_tick(1'b0, 1'b0, 1'b0, 1'b1, $urandom_range(49) == 0, 16'($urandom),
                      pick_read_index());
        drain_results();
        write_reg(dpq_pkg::CFG_STABLE_TIME, 16'hFFFE);
        for (n = 0; n < 3; n++)
            send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 5'(n));
        drain_results();

        if (fail_count == 0 && open_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
